FILE: rtl/bitmap_find_first_free_assert.svh
// Assertion macros for the bitmap find-first-free block.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef BITMAP_FIND_FIRST_FREE_ASSERT_SVH
`define BITMAP_FIND_FIRST_FREE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bitmap_find_first_free: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BFF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bitmap_find_first_free: next-cycle check failed");

`endif

FILE: rtl/bff_pkg.sv
// Shared constants, types and helper functions for the bitmap find-first-free block.
// No dependencies; the modules of the block and the testbench import this package.
package bff_pkg;

	// Sizes
	localparam int MAX_BITS_DEF = 4096;
	localparam int CMD_W        = 3;
	localparam int POS_W        = 12;
	localparam int CNT_W        = 13;
	localparam int WORD_W       = 64;
	localparam int BIT_SEL_W    = 6;
	localparam int WRD_W        = CNT_W - BIT_SEL_W + 1;
	localparam int APB_AW       = 3;
	localparam int APB_DW       = 32;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_TEST      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SET       = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FIND      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SET_ALL   = 3'd5;

	// Register map (index = paddr / 4)
	localparam logic [APB_AW-3:0] REG_BIT_COUNT = 1'b0;
	localparam logic [CNT_W-1:0]  BIT_COUNT_RST = 13'd4096;

	localparam logic [WORD_W-1:0] WORD_ONES = '1;

	// Command class seen by the controller
	typedef enum logic [1:0] {
		OP_BIT,
		OP_FIND,
		OP_FILL,
		OP_NONE
	} op_kind_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_BIT,
		ST_SCAN,
		ST_FILL,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic req_load;
		logic rd_bit;
		logic rd_cnt;
		logic cnt_clr;
		logic cnt_inc;
		logic bit_exec;
		logic wr_fill;
		logic fill_ones;
		logic res_oor;
		logic res_find;
		logic out_load;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_kind_t kind;
		logic     set_all;
		logic     oor;
		logic     no_words;
		logic     scan_hit;
		logic     last_word;
		logic     init_last;
	} dp_stat_t;

	// Index of the lowest set bit of a nonzero word, binary search
	function automatic logic [BIT_SEL_W-1:0] lowest_one(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0]    v;
		logic [BIT_SEL_W-1:0] n;
		v = w;
		n = '0;
		if (v[31:0] == 32'd0) begin
			n[5] = 1'b1;
			v = v >> 32;
		end
		if (v[15:0] == 16'd0) begin
			n[4] = 1'b1;
			v = v >> 16;
		end
		if (v[7:0] == 8'd0) begin
			n[3] = 1'b1;
			v = v >> 8;
		end
		if (v[3:0] == 4'd0) begin
			n[2] = 1'b1;
			v = v >> 4;
		end
		if (v[1:0] == 2'd0) begin
			n[1] = 1'b1;
			v = v >> 2;
		end
		if (v[0] == 1'b0) begin
			n[0] = 1'b1;
		end
		return n;
	endfunction

endpackage

FILE: rtl/bitmap_find_first_free.sv
// Bitmap occupancy map with find-first-free. Handles one transaction at a time:
// a test, set or clear goes through decode, bit access and done (decode goes
// straight to done when the position is out of range), a find scans the words in
// use up to and including the first word that is not full, and clear all or set all
// write every word in use; an unknown command, or a find or fill with no words in
// use, goes from decode straight to done. Scans and fills use the single word
// memory, read or written one 64-bit word per cycle. The controller is back in idle
// on the load edge, so the next transaction can be accepted while the previous
// result still waits in the output register; a finished transaction holds in its
// last state until that register is free. After reset a clearing pass writes every
// word to zero, ceil(MAX_BITS/64) words (64 by default), with no transaction
// accepted meanwhile; the configuration port works throughout.
// Depends on bff_pkg, bff_ctrl, bff_datapath and bitmap_find_first_free_assert.svh.
module bitmap_find_first_free #(
	parameter int MAX_BITS = bff_pkg::MAX_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bff_pkg::CMD_W-1:0]      command,
	input  logic [bff_pkg::POS_W-1:0]      position,
	// Output channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           bit_value,
	output logic [bff_pkg::POS_W-1:0]      found_position,
	output logic                           found,
	output logic                           out_of_range,
	// Configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bff_pkg::APB_AW-1:0]     paddr,
	input  logic [bff_pkg::APB_DW-1:0]     pwdata,
	output logic [bff_pkg::APB_DW-1:0]     prdata,
	output logic                           pready
);
	import bff_pkg::*;

	`include "bitmap_find_first_free_assert.svh"

	logic [CNT_W-1:0]    bit_count_q;
	logic [APB_AW-3:0]   reg_idx;
	logic                cfg_wr;
	dp_cmd_t             ctl;
	dp_stat_t            stat;

	// Register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_BIT_COUNT);
	assign prdata  = (reg_idx == REG_BIT_COUNT) ? APB_DW'(bit_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= BIT_COUNT_RST;
		end else if (cfg_wr) begin
			bit_count_q <= pwdata[CNT_W-1:0];
		end
	end

	bff_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	bff_datapath #(
		.MAX_BITS (MAX_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.bit_count      (bit_count_q),
		.command        (command),
		.position       (position),
		.bit_value      (bit_value),
		.found_position (found_position),
		.found          (found),
		.out_of_range   (out_of_range)
	);

	// Checks
	`BFF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`BFF_ASSERT_NOW(a_found_excludes_access, out_valid && found, !out_of_range && !bit_value)
	`BFF_ASSERT_NOW(a_oor_clean, out_valid && out_of_range, !found && found_position == 0)
	`BFF_ASSERT_NOW(a_found_below_count, out_valid && found, {1'b0, found_position} < bit_count_q)

endmodule

FILE: rtl/bff_datapath.sv
// Datapath of the bitmap find-first-free block: word memory, scan counter,
// find encoder, result and output registers. Depends on bff_pkg.
module bff_datapath #(
	parameter int MAX_BITS = bff_pkg::MAX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bff_pkg::dp_cmd_t              ctl,
	output bff_pkg::dp_stat_t             stat,
	input  logic [bff_pkg::CNT_W-1:0]     bit_count,
	input  logic [bff_pkg::CMD_W-1:0]     command,
	input  logic [bff_pkg::POS_W-1:0]     position,
	output logic                          bit_value,
	output logic [bff_pkg::POS_W-1:0]     found_position,
	output logic                          found,
	output logic                          out_of_range
);
	import bff_pkg::*;

	localparam int WORD_TOTAL = (MAX_BITS + WORD_W - 1) / WORD_W;
	localparam int ADDR_W     = (WORD_TOTAL > 1) ? $clog2(WORD_TOTAL) : 1;
	localparam int RES_W      = ADDR_W + BIT_SEL_W;

	logic [WORD_W-1:0] mem [WORD_TOTAL];
	logic [WORD_W-1:0] rdata_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [POS_W-1:0]  pos_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [ADDR_W-1:0] cnt_nxt;

	logic              res_bit_q;
	logic [POS_W-1:0]  res_pos_q;
	logic              res_found_q;
	logic              res_oor_q;

	logic [CNT_W-1:0]     eff_count;
	logic [WRD_W-1:0]     words;
	logic [ADDR_W-1:0]    pos_word;
	logic [BIT_SEL_W-1:0] pos_bit;
	logic [WORD_W-1:0]    bit_mask;
	logic [RES_W-1:0]     find_res;
	logic                 find_ok;
	logic                 rd_en;
	logic [ADDR_W-1:0]    raddr;
	logic                 we;
	logic [ADDR_W-1:0]    waddr;
	logic [WORD_W-1:0]    wdata;

	// Bit count clamped to the map size, and words in use
	always_comb begin
		if (32'(bit_count) > 32'(MAX_BITS)) begin
			eff_count = CNT_W'(MAX_BITS);
		end else begin
			eff_count = bit_count;
		end
		words = WRD_W'((14'(eff_count) + 14'd63) >> BIT_SEL_W);
	end

	assign pos_word = ADDR_W'(pos_q >> BIT_SEL_W);
	assign pos_bit  = pos_q[BIT_SEL_W-1:0];
	assign bit_mask = WORD_W'(1) << pos_bit;

	// Find result from the word just read
	assign find_res = {cnt_q, lowest_one(~rdata_q)};
	assign find_ok  = 32'(find_res) < 32'(eff_count);

	// Status toward the controller
	always_comb begin
		unique case (cmd_q) inside
			CMD_TEST, CMD_SET, CMD_CLEAR: stat.kind = OP_BIT;
			CMD_FIND:                     stat.kind = OP_FIND;
			CMD_CLEAR_ALL, CMD_SET_ALL:   stat.kind = OP_FILL;
			default:                      stat.kind = OP_NONE;
		endcase
		stat.set_all   = (cmd_q == CMD_SET_ALL);
		stat.oor       = ({1'b0, pos_q} >= eff_count);
		stat.no_words  = (words == '0);
		stat.scan_hit  = (rdata_q != WORD_ONES);
		stat.last_word = (32'(cnt_q) == (32'(words) - 32'd1));
		stat.init_last = (32'(cnt_q) == (WORD_TOTAL - 1));
	end

	// Word counter shared by scan, fill and the clearing pass
	always_comb begin
		if (ctl.cnt_clr) begin
			cnt_nxt = '0;
		end else if (ctl.cnt_inc) begin
			cnt_nxt = cnt_q + ADDR_W'(1);
		end else begin
			cnt_nxt = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_nxt;
		end
	end

	// Memory port selection
	always_comb begin
		rd_en = ctl.rd_bit | ctl.rd_cnt;
		raddr = ctl.rd_bit ? pos_word : cnt_nxt;
		we    = ctl.wr_fill | (ctl.bit_exec & (cmd_q != CMD_TEST));
		if (ctl.wr_fill) begin
			waddr = cnt_q;
			wdata = ctl.fill_ones ? WORD_ONES : '0;
		end else begin
			waddr = pos_word;
			wdata = (cmd_q == CMD_SET) ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
		end
	end

	// Word memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// Transaction capture
	always_ff @(posedge clk) begin
		if (ctl.req_load) begin
			cmd_q <= command;
			pos_q <= position;
		end
	end

	// Result registers, cleared at the start of each transaction
	always_ff @(posedge clk) begin
		if (ctl.req_load) begin
			res_bit_q   <= 1'b0;
			res_pos_q   <= '0;
			res_found_q <= 1'b0;
			res_oor_q   <= 1'b0;
		end else begin
			if (ctl.res_oor) begin
				res_oor_q <= 1'b1;
			end
			if (ctl.bit_exec && (cmd_q == CMD_TEST)) begin
				res_bit_q <= rdata_q[pos_bit];
			end
			if (ctl.res_find && find_ok) begin
				res_found_q <= 1'b1;
				res_pos_q   <= POS_W'(find_res);
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			bit_value      <= res_bit_q;
			found_position <= res_pos_q;
			found          <= res_found_q;
			out_of_range   <= res_oor_q;
		end
	end

endmodule

FILE: rtl/bff_ctrl.sv
// Controller of the bitmap find-first-free block: sequences decode, bit access,
// scan, fill and the reset clearing pass. Depends on bff_pkg.
module bff_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  bff_pkg::dp_stat_t  stat,
	output bff_pkg::dp_cmd_t   ctl
);
	import bff_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (stat.init_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_nxt = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (stat.kind)
					OP_BIT:  state_nxt = stat.oor ? ST_DONE : ST_BIT;
					OP_FIND: state_nxt = stat.no_words ? ST_DONE : ST_SCAN;
					OP_FILL: state_nxt = stat.no_words ? ST_DONE : ST_FILL;
					default: state_nxt = ST_DONE;
				endcase
			end
			ST_BIT: state_nxt = ST_DONE;
			ST_SCAN: begin
				if (stat.scan_hit || stat.last_word) state_nxt = ST_DONE;
			end
			ST_FILL: begin
				if (stat.last_word) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_INIT: begin
				ctl.wr_fill = 1'b1;
				ctl.cnt_inc = 1'b1;
			end
			ST_IDLE: begin
				ctl.req_load = accept;
			end
			ST_DECODE: begin
				unique case (stat.kind)
					OP_BIT: begin
						ctl.res_oor = stat.oor;
						ctl.rd_bit  = !stat.oor;
					end
					OP_FIND: begin
						ctl.rd_cnt  = !stat.no_words;
						ctl.cnt_clr = 1'b1;
					end
					OP_FILL: begin
						ctl.cnt_clr = 1'b1;
					end
					default: ;
				endcase
			end
			ST_BIT: begin
				ctl.bit_exec = 1'b1;
			end
			ST_SCAN: begin
				ctl.res_find = stat.scan_hit;
				if (!stat.scan_hit && !stat.last_word) begin
					ctl.rd_cnt  = 1'b1;
					ctl.cnt_inc = 1'b1;
				end
			end
			ST_FILL: begin
				ctl.wr_fill   = 1'b1;
				ctl.fill_ones = stat.set_all;
				ctl.cnt_inc   = 1'b1;
			end
			ST_DONE: begin
				ctl.out_load = out_free;
			end
			default: ;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: verif/tb.sv
// Self-checking testbench for bitmap_find_first_free: directed table, then random phases.
// Depends on bff_pkg and the RTL of the block; the expected results come from an
// in-file occupancy-map predictor.
module tb;
	import bff_pkg::*;

	localparam int MAP_BITS  = MAX_BITS_DEF;
	localparam int MAP_WORDS = MAP_BITS / 64;
	localparam int PHASES    = 12;
	localparam int PHASE_LEN = 120;
	localparam int DRAIN     = 80;

	// Codes the block must ignore
	localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

	typedef struct packed {
		logic             bit_value;
		logic [POS_W-1:0] found_position;
		logic             found;
		logic             out_of_range;
	} bff_result_t;

	typedef enum logic [1:0] {
		ROW_CMD,
		ROW_CHK,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [CNT_W-1:0] value;
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		bff_result_t      want;
	} dir_row_t;

	localparam bff_result_t R_ZERO = '0;
	localparam bff_result_t R_OOR  = '{1'b0, 12'd0, 1'b0, 1'b1};
	localparam bff_result_t R_ONE  = '{1'b1, 12'd0, 1'b0, 1'b0};

	// Directed rows: ROW_CHK carries a typed expectation, ROW_CMD uses the predictor
	localparam int DIR_ROWS = 29;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// fresh map after reset, full 4096-slot range
		'{ROW_CHK, 13'd0,    CMD_TEST,      12'd0,    R_ZERO},
		'{ROW_CHK, 13'd0,    CMD_FIND,      12'd0,    '{1'b0, 12'd0, 1'b1, 1'b0}},
		'{ROW_CHK, 13'd0,    CMD_SET,       12'd4095, R_ZERO},
		'{ROW_CHK, 13'd0,    CMD_TEST,      12'd4095, R_ONE},
		'{ROW_CHK, 13'd0,    CMD_SET_ALL,   12'd0,    R_ZERO},
		'{ROW_CHK, 13'd0,    CMD_FIND,      12'd0,    R_ZERO},
		'{ROW_CHK, 13'd0,    CMD_CLEAR,     12'd4095, R_ZERO},
		'{ROW_CHK, 13'd0,    CMD_FIND,      12'd0,    '{1'b0, 12'd4095, 1'b1, 1'b0}},
		'{ROW_CHK, 13'd0,    CMD_UNUSED_6,  12'd4095, R_ZERO},
		'{ROW_CHK, 13'd0,    CMD_UNUSED_7,  12'd0,    R_ZERO},
		'{ROW_CHK, 13'd0,    CMD_CLEAR_ALL, 12'd0,    R_ZERO},
		'{ROW_CHK, 13'd0,    CMD_TEST,      12'd4095, R_ZERO},
		// single slot: the free zero above the count must not be reported
		'{ROW_CFG, 13'd1,    CMD_TEST,      12'd0,    R_ZERO},
		'{ROW_CHK, 13'd0,    CMD_TEST,      12'd1,    R_OOR},
		'{ROW_CHK, 13'd0,    CMD_SET,       12'd0,    R_ZERO},
		'{ROW_CHK, 13'd0,    CMD_FIND,      12'd0,    R_ZERO},
		'{ROW_CHK, 13'd0,    CMD_SET_ALL,   12'd0,    R_ZERO},
		// set all touched word 0 only
		'{ROW_CFG, 13'd100,  CMD_TEST,      12'd0,    R_ZERO},
		'{ROW_CMD, 13'd0,    CMD_FIND,      12'd0,    R_ZERO},
		'{ROW_CHK, 13'd0,    CMD_TEST,      12'd100,  R_OOR},
		'{ROW_CMD, 13'd0,    CMD_TEST,      12'd99,   R_ZERO},
		// empty map: every bit access out of range, find and fill report nothing
		'{ROW_CFG, 13'd0,    CMD_TEST,      12'd0,    R_ZERO},
		'{ROW_CHK, 13'd0,    CMD_TEST,      12'd0,    R_OOR},
		'{ROW_CHK, 13'd0,    CMD_FIND,      12'd0,    R_ZERO},
		'{ROW_CHK, 13'd0,    CMD_SET_ALL,   12'd0,    R_ZERO},
		// count above the map size clamps to the full map
		'{ROW_CFG, 13'd8191, CMD_TEST,      12'd0,    R_ZERO},
		'{ROW_CMD, 13'd0,    CMD_TEST,      12'd4095, R_ZERO},
		'{ROW_CMD, 13'd0,    CMD_FIND,      12'd0,    R_ZERO},
		'{ROW_CMD, 13'd0,    CMD_SET_ALL,   12'd0,    R_ZERO}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [CMD_W-1:0]    command = '0;
	logic [POS_W-1:0]    position = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                bit_value;
	logic [POS_W-1:0]    found_position;
	logic                found;
	logic                out_of_range;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	// Predictor state
	logic [63:0]         slot_map [MAP_WORDS];
	logic [CNT_W-1:0]    slot_count;
	bff_result_t         pending_results [$];
	int                  mismatches = 0;
	bit                  calm_phase = 1'b0;

	bitmap_find_first_free u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.position       (position),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.bit_value      (bit_value),
		.found_position (found_position),
		.found          (found),
		.out_of_range   (out_of_range),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Safety net against a hung handshake
	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	// Slots in use; counts above the map size clamp
	function automatic int slots_in_use();
		return (int'(slot_count) > MAP_BITS) ? MAP_BITS : int'(slot_count);
	endfunction

	// Apply one transaction to the occupancy map and return its result
	function automatic bff_result_t predict_command(logic [CMD_W-1:0] cmd,
			logic [POS_W-1:0] pos);
		bff_result_t r;
		int          lim;
		int          words;
		int          zero_at;
		bit          done;
		r = '0;
		lim = slots_in_use();
		words = (lim + 63) / 64;
		done = 1'b0;
		case (cmd)
			CMD_TEST, CMD_SET, CMD_CLEAR: begin
				if (int'(pos) >= lim) begin
					r.out_of_range = 1'b1;
				end else if (cmd == CMD_TEST) begin
					r.bit_value = slot_map[pos[11:6]][pos[5:0]];
				end else begin
					slot_map[pos[11:6]][pos[5:0]] = (cmd == CMD_SET);
				end
			end
			CMD_FIND: begin
				for (int w = 0; w < words && !done; w++) begin
					if (slot_map[w] != '1) begin
						done = 1'b1;
						zero_at = 64;
						for (int b = 63; b >= 0; b--) begin
							if (!slot_map[w][b])
								zero_at = b;
						end
						if (w * 64 + zero_at < lim) begin
							r.found = 1'b1;
							r.found_position = POS_W'(w * 64 + zero_at);
						end
					end
				end
			end
			CMD_CLEAR_ALL, CMD_SET_ALL: begin
				for (int w = 0; w < words; w++)
					slot_map[w] = (cmd == CMD_SET_ALL) ? '1 : '0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (calm_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [POS_W-1:0] pos_in_use();
		int lim;
		lim = slots_in_use();
		if (lim == 0)
			return POS_W'($urandom_range(0, MAP_BITS - 1));
		return POS_W'($urandom_range(0, lim - 1));
	endfunction

	task automatic log_failure(input string what, input bff_result_t want,
			input bff_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: want bv=%0d pos=%0d fnd=%0d oor=%0d, got bv=%0d pos=%0d fnd=%0d oor=%0d",
				$realtime, what, want.bit_value, want.found_position, want.found,
				want.out_of_range, got.bit_value, got.found_position, got.found,
				got.out_of_range);
	endtask

	// Send one transaction, record its expectation, then maybe idle the input
	task automatic issue(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input bit typed, input bff_result_t typed_res, output bff_result_t res);
		int gap;
		in_valid <= 1'b1;
		command <= cmd;
		position <= pos;
		do @(posedge clk); while (in_stall);
		res = predict_command(cmd, pos);
		pending_results.push_back(typed ? typed_res : res);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Block idle: input dropped and every expected result back
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write bit_count, then read it back
	task automatic write_bit_count(input logic [CNT_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_BIT_COUNT, 2'b00};
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		slot_count = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DW'(value)) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t bit_count readback: want %0d, got %0d", $realtime,
					value, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result checker
	always @(posedge clk) begin : check_results
		bff_result_t got;
		bff_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{bit_value, found_position, found, out_of_range};
			if (pending_results.size() == 0) begin
				log_failure("unexpected result", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.bit_value !== want.bit_value ||
						got.found_position !== want.found_position ||
						got.found !== want.found ||
						got.out_of_range !== want.out_of_range)
					log_failure("result mismatch", want, got);
			end
		end
	end

	// Receiver stalls
	initial begin : stall_results
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	end

	// Main sequence
	initial begin : stimulus
		bff_result_t res;
		int          phase_end;
		int          sent;
		int          r;
		logic [CNT_W-1:0] cnt;

		foreach (slot_map[w])
			slot_map[w] = '0;
		slot_count = BIT_COUNT_RST;
		sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				wait_idle();
				write_bit_count(DIRECTED[i].value);
			end else begin
				issue(DIRECTED[i].cmd, DIRECTED[i].pos, DIRECTED[i].kind == ROW_CHK,
					DIRECTED[i].want, res);
			end
		end

		// Random phases, each with its own slot count
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       cnt = 13'd4096;
				1:       cnt = 13'd1;
				2:       cnt = 13'd64;
				3:       cnt = 13'd65;
				4:       cnt = 13'd4095;
				5:       cnt = 13'd63;
				6:       cnt = 13'd128;
				8, 9:    cnt = CNT_W'($urandom_range(1, 300));
				11:      cnt = 13'd4096;
				default: cnt = CNT_W'($urandom_range(2, 4096));
			endcase
			wait_idle();
			calm_phase = ($urandom_range(0, 3) == 0);
			write_bit_count(cnt);
			phase_end = sent + PHASE_LEN;
			while (sent < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 30) begin
					// allocate: find the first free slot and take it
					issue(CMD_FIND, POS_W'($urandom), 1'b0, '0, res);
					sent++;
					if (res.found) begin
						issue(CMD_SET, res.found_position, 1'b0, '0, res);
						sent++;
					end
				end else if (r < 45) begin
					issue(CMD_CLEAR, pos_in_use(), 1'b0, '0, res);
					sent++;
				end else if (r < 60) begin
					issue(CMD_TEST, pos_in_use(), 1'b0, '0, res);
					sent++;
				end else if (r < 68) begin
					// around the end of the range
					issue(CMD_CLEAR - CMD_W'($urandom_range(0, 2)),
						POS_W'(slots_in_use() - 1 + $urandom_range(0, 3)), 1'b0, '0, res);
					sent++;
				end else if (r < 78) begin
					issue(CMD_FIND, POS_W'($urandom), 1'b0, '0, res);
					sent++;
				end else if (r < 82) begin
					// fill the map, then punch a few holes
					issue(CMD_SET_ALL, POS_W'($urandom), 1'b0, '0, res);
					sent++;
					repeat ($urandom_range(0, 4)) begin
						issue(CMD_CLEAR, pos_in_use(), 1'b0, '0, res);
						sent++;
					end
				end else if (r < 85) begin
					issue(CMD_CLEAR_ALL, POS_W'($urandom), 1'b0, '0, res);
					sent++;
				end else if (r < 88) begin
					issue(($urandom_range(0, 1) != 0) ? CMD_UNUSED_6 : CMD_UNUSED_7,
						POS_W'($urandom), 1'b0, '0, res);
					sent++;
				end else begin
					issue(CMD_W'($urandom_range(0, 7)), POS_W'($urandom), 1'b0, '0, res);
					sent++;
				end
			end
		end

		// Drain and report
		wait_idle();
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
